### hdl/rhlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhlf_pkg
// Shared widths, limits and the job record passed from front to back end.
// ----------------------------------------------------------------------------
package rhlf_pkg;

    localparam int H_W     = 32;            // height, signed Q24.8
    localparam int CNT_W   = 7;             // row position, hole count, distance
    localparam int MAX_ROW = 64;            // widest row honoured
    localparam int NUM_W   = H_W + CNT_W;   // signed interpolation numerator
    localparam int MAG_W   = NUM_W - 1;     // numerator magnitude

    typedef struct packed {
        logic               known;          // closes on a measured cell
        logic               is_end;         // last cell of the row
        logic               prior_valid;    // a measured cell preceded the holes
        logic [CNT_W-1:0]   holes;          // held-back holes
        logic [H_W-1:0]     height;         // new height, or fill height at row end
        logic [H_W-1:0]     prior;          // previous measured height
    } job_t;

endpackage

### hdl/rhlf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhlf_front
// Takes cells, tracks row position and held-back holes, queues a job for every
// measured cell and for every row end.
// ----------------------------------------------------------------------------
module rhlf_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [rhlf_pkg::CNT_W-1:0]  cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [rhlf_pkg::H_W-1:0] cell_height,
    input  logic                        has_data,
    input  logic                        q_full,
    output logic                        q_push,
    output rhlf_pkg::job_t              q_job
);

    logic [rhlf_pkg::CNT_W-1:0] row_width_reg;
    logic [rhlf_pkg::CNT_W-1:0] column_pos_reg, column_pos_next;
    logic [rhlf_pkg::CNT_W-1:0] holes_reg, holes_next;
    logic [rhlf_pkg::H_W-1:0]   prior_reg, prior_next;
    logic                       prior_valid_reg, prior_valid_next;

    logic [rhlf_pkg::CNT_W-1:0] width_eff;
    logic [rhlf_pkg::CNT_W:0]   pos_plus;
    logic                       is_end;
    logic                       accept;

    always_comb
    begin
        if (row_width_reg == '0)
            width_eff = rhlf_pkg::CNT_W'(1);
        else if (row_width_reg > rhlf_pkg::CNT_W'(rhlf_pkg::MAX_ROW))
            width_eff = rhlf_pkg::CNT_W'(rhlf_pkg::MAX_ROW);
        else
            width_eff = row_width_reg;
    end

    assign pos_plus = {1'b0, column_pos_reg} + (rhlf_pkg::CNT_W+1)'(1);
    assign is_end   = pos_plus >= {1'b0, width_eff};
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = accept && (has_data || is_end);

    always_comb
    begin
        q_job.known       = has_data;
        q_job.is_end      = is_end;
        q_job.prior_valid = prior_valid_reg;
        q_job.holes       = holes_reg;
        q_job.prior       = prior_reg;
        if (has_data)
            q_job.height = cell_height;
        else if (prior_valid_reg)
            q_job.height = prior_reg;
        else
            q_job.height = '0;
    end

    always_comb
    begin
        column_pos_next  = column_pos_reg;
        holes_next       = holes_reg;
        prior_next       = prior_reg;
        prior_valid_next = prior_valid_reg;
        if (accept)
        begin
            if (is_end)
            begin
                column_pos_next  = '0;
                holes_next       = '0;
                prior_next       = '0;
                prior_valid_next = 1'b0;
            end
            else
            begin
                column_pos_next = pos_plus[rhlf_pkg::CNT_W-1:0];
                if (has_data)
                begin
                    holes_next       = '0;
                    prior_next       = cell_height;
                    prior_valid_next = 1'b1;
                end
                else
                begin
                    holes_next = holes_reg + rhlf_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg   <= rhlf_pkg::CNT_W'(rhlf_pkg::MAX_ROW);
            column_pos_reg  <= '0;
            holes_reg       <= '0;
            prior_reg       <= '0;
            prior_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                row_width_reg <= cfg_wr_data;
            column_pos_reg  <= column_pos_next;
            holes_reg       <= holes_next;
            prior_reg       <= prior_next;
            prior_valid_reg <= prior_valid_next;
        end
    end

endmodule

### hdl/rhlf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhlf_queue
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module rhlf_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rhlf_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output rhlf_pkg::job_t  head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rhlf_pkg::job_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
            return '0;
        else
            return p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

### hdl/rhlf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhlf_div
// Serial restoring divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module rhlf_div
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [rhlf_pkg::NUM_W-1:0]  num,
    input  logic [rhlf_pkg::CNT_W-1:0]         den,
    output logic                               done,
    output logic signed [rhlf_pkg::H_W-1:0]    quot
);

    localparam int MAG_W  = rhlf_pkg::MAG_W;
    localparam int STEP_W = $clog2(MAG_W);

    logic                       busy_reg;
    logic                       done_reg;
    logic                       neg_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [MAG_W-1:0]           quo_reg;
    logic [rhlf_pkg::CNT_W-1:0] rem_reg;
    logic [rhlf_pkg::CNT_W-1:0] den_reg;

    logic [rhlf_pkg::NUM_W-1:0] num_neg;
    logic [MAG_W-1:0]           mag;
    logic [rhlf_pkg::CNT_W:0]   trial;
    logic                       fits;
    logic [rhlf_pkg::CNT_W:0]   trial_sub;

    assign num_neg   = -num;
    assign mag       = num[rhlf_pkg::NUM_W-1] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0];
    assign trial     = {rem_reg, quo_reg[MAG_W-1]};
    assign fits      = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    // magnitude of a quotient between two heights always fits the height width
    assign quot = neg_reg ? -$signed(quo_reg[rhlf_pkg::H_W-1:0])
                          :  $signed(quo_reg[rhlf_pkg::H_W-1:0]);
    assign done = done_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[rhlf_pkg::NUM_W-1];
            quo_reg <= mag;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[MAG_W-2:0], fits};
            rem_reg <= fits ? trial_sub[rhlf_pkg::CNT_W-1:0] : trial[rhlf_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_W'(MAG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

endmodule

### hdl/rhlf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhlf_back
// Runs queued jobs: emits held-back holes (interpolated or copied), then the
// closing cell, through a registered output stage.
// ----------------------------------------------------------------------------
module rhlf_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  rhlf_pkg::job_t                  q_job,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [rhlf_pkg::H_W-1:0] out_height,
    output logic                            was_filled,
    output logic                            row_end,
    output logic                            last_of_run
);

    localparam int H_W   = rhlf_pkg::H_W;
    localparam int CNT_W = rhlf_pkg::CNT_W;
    localparam int NUM_W = rhlf_pkg::NUM_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_NEXT   = 3'd2;
    localparam logic [2:0] ST_DSTART = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]               state_reg;
    rhlf_pkg::job_t           job_reg;
    logic [CNT_W-1:0]         k_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic signed [H_W:0]      diff_reg;
    logic [H_W-1:0]           res_reg;
    logic                     res_fill_reg, res_end_reg, res_last_reg;

    logic                     out_valid_reg;
    logic [H_W-1:0]           out_height_reg;
    logic                     out_fill_reg, out_end_reg, out_last_reg;

    logic [CNT_W-1:0]         distance;
    logic signed [NUM_W:0]    prod;
    logic                     div_start, div_done;
    logic signed [H_W-1:0]    div_quot;
    logic                     slot_free;

    assign distance  = job_reg.holes + CNT_W'(1);
    assign prod      = $signed(job_reg.prior) * $signed({1'b0, distance});
    assign div_start = state_reg == ST_DSTART;
    assign slot_free = !out_valid_reg || !out_stall;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    rhlf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (distance),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                    job_reg <= q_job;
            end
            ST_MUL:
            begin
                // numerator of the first hole builds on prior * distance
                num_reg  <= prod[NUM_W-1:0];
                diff_reg <= $signed({job_reg.height[H_W-1], job_reg.height})
                          - $signed({job_reg.prior[H_W-1], job_reg.prior});
            end
            ST_NEXT:
            begin
                if (k_reg < job_reg.holes)
                begin
                    if (job_reg.known && job_reg.prior_valid)
                    begin
                        num_reg <= num_reg + {{(NUM_W-H_W-1){diff_reg[H_W]}}, diff_reg};
                    end
                    else
                    begin
                        res_reg      <= job_reg.height;
                        res_fill_reg <= 1'b1;
                        res_end_reg  <= 1'b0;
                        res_last_reg <= 1'b0;
                    end
                end
                else
                begin
                    res_reg      <= job_reg.height;
                    res_fill_reg <= !job_reg.known;
                    res_end_reg  <= job_reg.is_end;
                    res_last_reg <= 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_reg      <= div_quot;
                    res_fill_reg <= 1'b1;
                    res_end_reg  <= 1'b0;
                    res_last_reg <= 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        if (state_reg == ST_OUT && slot_free)
        begin
            out_height_reg <= res_reg;
            out_fill_reg   <= res_fill_reg;
            out_end_reg    <= res_end_reg;
            out_last_reg   <= res_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_OUT && slot_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                    state_reg <= ST_NEXT;
                ST_NEXT:
                begin
                    if (k_reg < job_reg.holes && job_reg.known && job_reg.prior_valid)
                        state_reg <= ST_DSTART;
                    else
                        state_reg <= ST_OUT;
                end
                ST_DSTART:
                    state_reg <= ST_DIV;
                ST_DIV:
                begin
                    if (div_done)
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (slot_free)
                    begin
                        k_reg     <= k_reg + CNT_W'(1);
                        state_reg <= res_last_reg ? ST_IDLE : ST_NEXT;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_height  = out_height_reg;
    assign was_filled  = out_fill_reg;
    assign row_end     = out_end_reg;
    assign last_of_run = out_last_reg;

endmodule

### hdl/row_hole_linear_fill_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_hole_linear_fill_top
// Fills holes in height-grid rows by linear interpolation, Q24.8 heights.
// ----------------------------------------------------------------------------
// A hole in mid-row is taken as any other cell and gives no result until the
// next measured cell or the row end. A measured cell that closes a run of p
// holes gives p + 1 results; each interpolated hole passes through the
// 38-step serial divider in the back end, a copied hole or the closing cell
// does not, and each job is first loaded from the queue. The front end keeps
// taking cells while the back end works until the job queue (QUEUE_DEPTH
// entries) is full. The user writes row_width only while idle; the block does
// not enforce it. Zero acts as one and values above 64 act as 64.
module row_hole_linear_fill_top
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [rhlf_pkg::CNT_W-1:0]      cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [rhlf_pkg::H_W-1:0] cell_height,
    input  logic                            has_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [rhlf_pkg::H_W-1:0] out_height,
    output logic                            was_filled,
    output logic                            row_end,
    output logic                            last_of_run
);

    logic           q_push, q_full, q_pop, q_valid;
    rhlf_pkg::job_t push_job, head_job;

    rhlf_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cell_height (cell_height),
        .has_data    (has_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    rhlf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (head_job)
    );

    rhlf_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_job       (head_job),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_height  (out_height),
        .was_filled  (was_filled),
        .row_end     (row_end),
        .last_of_run (last_of_run)
    );

    // a job is never pushed into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

    // the row-end result closes its transaction
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_end |-> last_of_run)
        else $error("row end without last_of_run");

    // a measured cell is always the last result of its transaction
    a_measured_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !was_filled |-> last_of_run)
        else $error("measured result not last of run");

endmodule

### sim/tb_row_hole_linear_fill_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_row_hole_linear_fill_top
// Self-checking bench for the row hole linear fill block.
// Directed rows cover the extreme heights, leading and trailing holes, empty
// rows, a zero width and a width change part way through a row. Random phases
// follow, each with its own row width and hole density. A scoreboard predicts
// every emitted cell and checks each output transaction.
// ----------------------------------------------------------------------------

class fill_scoreboard;

    typedef struct packed {
        logic signed [rhlf_pkg::H_W-1:0] height;
        logic                            filled;
        logic                            rend;
        logic                            last;
    } fill_cell_t;

    fill_cell_t                      expected_cells[$];
    logic [rhlf_pkg::CNT_W-1:0]      width_reg;
    logic [rhlf_pkg::CNT_W-1:0]      column;
    logic [rhlf_pkg::CNT_W-1:0]      holes;
    logic signed [rhlf_pkg::H_W-1:0] prior;
    bit                              prior_ok;
    int                              errors;

    function new();
        width_reg = 7'd64;
        errors    = 0;
        clear_row();
    endfunction

    function void clear_row();
        column   = '0;
        holes    = '0;
        prior    = '0;
        prior_ok = 1'b0;
    endfunction

    function void set_width(logic [rhlf_pkg::CNT_W-1:0] w);
        width_reg = w;
    endfunction

    function int pending();
        return expected_cells.size();
    endfunction

    function void push_cell(logic signed [rhlf_pkg::H_W-1:0] h, logic f, logic re);
        fill_cell_t c;
        c.height = h;
        c.filled = f;
        c.rend   = re;
        c.last   = 1'b0;
        expected_cells.push_back(c);
    endfunction

    // Predict the cells released by one accepted input transaction.
    function void note_cell(logic signed [rhlf_pkg::H_W-1:0] h, logic known);
        int                              eff;
        int                              first;
        int                              tail;
        bit                              is_end;
        longint                          d;
        longint                          k;
        longint                          v;
        logic signed [rhlf_pkg::H_W-1:0] fill;

        eff = width_reg;
        if (eff < 1)
            eff = 1;
        if (eff > rhlf_pkg::MAX_ROW)
            eff = rhlf_pkg::MAX_ROW;
        is_end = (int'(column) + 1 >= eff);
        first  = expected_cells.size();

        if (known) begin
            d = longint'(holes) + 1;
            for (k = 1; k <= longint'(holes); k++) begin
                if (prior_ok)
                    v = (longint'(h) * k + longint'(prior) * (d - k)) / d;
                else
                    v = longint'(h);
                push_cell(v[rhlf_pkg::H_W-1:0], 1'b1, 1'b0);
            end
            push_cell(h, 1'b0, is_end);
            prior    = h;
            prior_ok = 1'b1;
            holes    = '0;
        end
        else if (is_end) begin
            fill = prior_ok ? prior : '0;
            for (k = 0; k < longint'(holes); k++)
                push_cell(fill, 1'b1, 1'b0);
            push_cell(fill, 1'b1, 1'b1);
        end
        else begin
            holes = holes + rhlf_pkg::CNT_W'(1);
        end

        if (expected_cells.size() > first) begin
            tail = expected_cells.size() - 1;
            expected_cells[tail].last = 1'b1;
        end

        if (is_end)
            clear_row();
        else
            column = column + rhlf_pkg::CNT_W'(1);
    endfunction

    task report(string what);
        $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    task check_cell(logic signed [rhlf_pkg::H_W-1:0] h, logic f, logic re, logic lr);
        fill_cell_t exp_c;
        if (expected_cells.size() == 0) begin
            report($sformatf("unexpected cell height %h filled %b row_end %b last %b",
                             h, f, re, lr));
        end
        else begin
            exp_c = expected_cells.pop_front();
            if (h !== exp_c.height || f !== exp_c.filled || re !== exp_c.rend ||
                lr !== exp_c.last)
                report($sformatf({"height %h/%h filled %b/%b row_end %b/%b ",
                                  "last %b/%b (got/expected)"},
                                 h, exp_c.height, f, exp_c.filled, re, exp_c.rend,
                                 lr, exp_c.last));
        end
    endtask

endclass

module tb_row_hole_linear_fill_top;

    localparam int TARGET_CELLS  = 330;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 300;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_wr_en;
    logic [rhlf_pkg::CNT_W-1:0]       cfg_wr_data;
    logic                             in_valid;
    logic                             in_stall;
    logic signed [rhlf_pkg::H_W-1:0]  cell_height;
    logic                             has_data;
    logic                             out_valid;
    logic                             out_stall;
    logic signed [rhlf_pkg::H_W-1:0]  out_height;
    logic                             was_filled;
    logic                             row_end;
    logic                             last_of_run;

    fill_scoreboard sb;
    int             cells_sent = 0;
    bit             hold_req   = 1'b0;

    row_hole_linear_fill_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cell_height (cell_height),
        .has_data    (has_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_height  (out_height),
        .was_filled  (was_filled),
        .row_end     (row_end),
        .last_of_run (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [rhlf_pkg::H_W-1:0] rand_height();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            4, 5, 6: return $urandom;
            default: return $signed(32'($urandom_range(0, 65535))) - 32'sd32768;
        endcase
    endfunction

    function automatic logic [rhlf_pkg::CNT_W-1:0] pick_width();
        case ($urandom_range(0, 19))
            0:             return 7'd0;
            1:             return 7'd1;
            2:             return 7'd64;
            3:             return 7'($urandom_range(65, 127));
            4, 5, 6, 7:    return 7'($urandom_range(9, 16));
            default:       return 7'($urandom_range(2, 8));
        endcase
    endfunction

    // Offer one cell, hold it until taken, then optionally idle.
    task automatic offer_cell(input logic signed [rhlf_pkg::H_W-1:0] h, input logic known,
                              input bit burst);
        int gap;
        in_valid    <= 1'b1;
        cell_height <= h;
        has_data    <= known;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        cells_sent++;
        gap = burst ? 0 : rand_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Let the monitor fold in the last accepted transaction before counting.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_row_width(input logic [rhlf_pkg::CNT_W-1:0] w);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_phase(input int cells, input int known_pct, input bit burst);
        int i;
        for (i = 0; i < cells; i++) begin
            offer_cell(rand_height(), $urandom_range(0, 99) < known_pct, burst);
            if ($urandom_range(0, 59) == 0)
                wait_drained();
        end
    endtask

    // Receiver: random stalls, calm stretches, and one long hold on request.
    initial
    begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0) begin
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 199) == 0)
                    calm_left = $urandom_range(20, 150);
                else if ($urandom_range(0, 3) == 0)
                    stall_left = rand_gap();
            end
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Check output first, then fold in config and input transactions.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_cell(out_height, was_filled, row_end, last_of_run);
            if (cfg_wr_en)
                sb.set_width(cfg_wr_data);
            if (in_valid && !in_stall)
                sb.note_cell(cell_height, has_data);
        end
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int                         phase;
        int                         eff;
        int                         rows;
        int                         cells;
        int                         pct;
        logic [rhlf_pkg::CNT_W-1:0] w;

        sb = new();
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        cell_height <= '0;
        has_data    <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme heights across two holes, leading and trailing holes, an empty row.
        write_row_width(7'd4);
        offer_cell(32'sh7FFF_FFFF, 1'b1, 1'b0);
        offer_cell(rand_height(), 1'b0, 1'b0);
        offer_cell(rand_height(), 1'b0, 1'b0);
        offer_cell(32'sh8000_0000, 1'b1, 1'b0);
        offer_cell(rand_height(), 1'b0, 1'b0);
        offer_cell(rand_height(), 1'b0, 1'b0);
        offer_cell(32'sd25600, 1'b1, 1'b0);
        offer_cell(rand_height(), 1'b0, 1'b0);
        offer_cell(rand_height(), 1'b0, 1'b0);
        offer_cell(rand_height(), 1'b0, 1'b0);
        offer_cell(rand_height(), 1'b0, 1'b0);
        offer_cell(rand_height(), 1'b0, 1'b0);
        offer_cell(-32'sd256, 1'b1, 1'b0);
        offer_cell(32'sd512, 1'b1, 1'b0);
        offer_cell(rand_height(), 1'b0, 1'b0);
        offer_cell(32'sh1234_5678, 1'b1, 1'b0);

        // Width zero acts as one.
        write_row_width(7'd0);
        offer_cell(32'sd5, 1'b1, 1'b0);
        offer_cell(rand_height(), 1'b0, 1'b0);

        // Narrow the row below the current position: next cell ends it.
        write_row_width(7'd4);
        offer_cell(rand_height(), 1'b0, 1'b0);
        offer_cell(32'sh0000_0300, 1'b1, 1'b0);
        offer_cell(rand_height(), 1'b0, 1'b0);
        write_row_width(7'd2);
        offer_cell(rand_height(), 1'b0, 1'b0);

        phase = 0;
        while (cells_sent < TARGET_CELLS) begin
            case (phase)
                0:       w = 7'd127;
                1:       w = 7'd64;
                3:       w = 7'd16;
                default: w = pick_width();
            endcase
            write_row_width(w);
            eff = (w == 0) ? 1 : ((w > rhlf_pkg::MAX_ROW) ? rhlf_pkg::MAX_ROW : int'(w));
            if (phase == 3) begin
                // Back-to-back cells against a held receiver, then drain fully.
                hold_req = 1'b1;
                run_phase(48, 90, 1'b1);
                wait_drained();
            end
            else begin
                rows  = (eff > 16) ? 1 : $urandom_range(1, 3);
                cells = eff * rows;
                if ($urandom_range(0, 2) == 0)
                    cells += $urandom_range(0, eff - 1);
                case ($urandom_range(0, 3))
                    0:       pct = 5;
                    1:       pct = 35;
                    2:       pct = 65;
                    default: pct = 95;
                endcase
                run_phase(cells, pct, $urandom_range(0, 4) == 0);
            end
            phase++;
        end

        wait_drained();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
